// ===== src/aupf_pkg.sv =====
// Shared types and constants for the advertising UUID prefix filter.
// No dependencies; imported by every module of the block.
package aupf_pkg;

  localparam int unsigned PrefixLimit = 10;  // bytes held by head plus tail
  localparam int unsigned UuidDataLen = 16;
  localparam logic [7:0]  UuidFieldLen = 8'(UuidDataLen + 1);

  localparam logic [7:0]  ListTypeRst = 8'h07;
  localparam logic [63:0] PrefixHeadRst = 64'h7e31_35d4_12f3_11e9;
  localparam logic [15:0] PrefixTailRst = 16'hab14;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIST_TYPE   = 2'd0,
    CFG_PREFIX_HEAD = 2'd1,
    CFG_PREFIX_TAIL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_MATCH     = 2'd0,
    VERDICT_NOMATCH   = 2'd1,
    VERDICT_MALFORMED = 2'd2,
    VERDICT_TOOLONG   = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0]  list_type;
    logic [63:0] prefix_head;
    logic [15:0] prefix_tail;
  } cfg_t;

  typedef struct packed {
    verdict_e   verdict;
    logic [5:0] bytes_seen;
  } result_t;

  // Expected prefix byte at data offset idx; byte 0 sits in the top of head.
  function automatic logic [7:0] expected_byte(cfg_t cfg, logic [3:0] idx);
    logic [8*PrefixLimit-1:0] pfx;
    logic [7:0]               res;
    pfx = {cfg.prefix_head, cfg.prefix_tail};
    res = 8'h00;
    for (int i = 0; i < PrefixLimit; i++) begin
      if (idx == 4'(i)) begin
        res = pfx[8*(PrefixLimit-1-i) +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== src/aupf_parse.sv =====
// Length-type-data walker: per-byte state update and final verdict.
// Depends on aupf_pkg.
module aupf_parse import aupf_pkg::*; #(
  parameter int unsigned MAX_ADV_LEN  = 31,
  parameter int unsigned PREFIX_BYTES = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] payload_byte_i,
  input  logic       final_byte_i,
  input  cfg_t       cfg_i,
  output logic       push_o,
  output result_t    result_o
);

  localparam int unsigned CntW = $clog2(MAX_ADV_LEN + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_ADV_LEN + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ADV_LEN);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic            kind_q, kind_d;
  logic            peq_q, peq_d;
  verdict_e        early_q, early_d;
  logic            decided_q, decided_d;

  logic [7:0]      data_off;
  verdict_e        verdict;

  assign data_off = pos_q - 8'd1;

  always_comb begin
    cnt_d     = (cnt_q < CntSat) ? cnt_q + CntW'(1) : cnt_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    len_d     = len_q;
    kind_d    = kind_q;
    peq_d     = peq_q;
    early_d   = early_q;
    decided_d = decided_q;

    if (!decided_q) begin
      if (rem_q == 8'd0) begin
        if (payload_byte_i == 8'd0) begin
          decided_d = 1'b1;
          early_d   = VERDICT_MALFORMED;
        end else begin
          len_d  = payload_byte_i;
          rem_d  = payload_byte_i;
          pos_d  = 8'd0;
          kind_d = 1'b0;
          peq_d  = 1'b1;
        end
      end else begin
        if (pos_q == 8'd0) begin
          kind_d = (payload_byte_i == cfg_i.list_type) && (len_q == UuidFieldLen);
        end else if (data_off < 8'(PREFIX_BYTES) &&
                     payload_byte_i != expected_byte(cfg_i, data_off[3:0])) begin
          peq_d = 1'b0;
        end
        pos_d = pos_q + 8'd1;
        rem_d = rem_q - 8'd1;
        if (rem_d == 8'd0 && kind_d && peq_d) begin
          decided_d = 1'b1;
          early_d   = VERDICT_MATCH;
        end
      end
    end

    if (cnt_d > CntMax) begin
      verdict = VERDICT_TOOLONG;
    end else if (decided_d) begin
      verdict = early_d;
    end else if (rem_d != 8'd0) begin
      verdict = VERDICT_MALFORMED;
    end else begin
      verdict = VERDICT_NOMATCH;
    end
  end

  assign push_o              = accept_i && final_byte_i;
  assign result_o.verdict    = verdict;
  assign result_o.bytes_seen = 6'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rem_q     <= 8'd0;
      pos_q     <= 8'd0;
      len_q     <= 8'd0;
      kind_q    <= 1'b0;
      peq_q     <= 1'b1;
      early_q   <= VERDICT_NOMATCH;
      decided_q <= 1'b0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        // verdict given, start over for the next payload
        cnt_q     <= '0;
        rem_q     <= 8'd0;
        pos_q     <= 8'd0;
        len_q     <= 8'd0;
        kind_q    <= 1'b0;
        peq_q     <= 1'b1;
        early_q   <= VERDICT_NOMATCH;
        decided_q <= 1'b0;
      end else begin
        cnt_q     <= cnt_d;
        rem_q     <= rem_d;
        pos_q     <= pos_d;
        len_q     <= len_d;
        kind_q    <= kind_d;
        peq_q     <= peq_d;
        early_q   <= early_d;
        decided_q <= decided_d;
      end
    end
  end

endmodule

// ===== src/aupf_result_buf.sv =====
// Two-entry result buffer between the parser and the output channel.
// Depends on aupf_pkg.
module aupf_result_buf import aupf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign result_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/adv_uuid128_prefix_filter.sv =====
// Top level of the advertising UUID prefix filter: config registers,
// parser and result buffer. Depends on aupf_pkg, aupf_parse, aupf_result_buf.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | to block  | in_valid_i / in_stall_o | payload_byte_i, final_byte_i
//   out     | from block| out_valid_o/ out_stall_i| verdict_o, bytes_seen_o
//   cfg     | to block  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One byte per cycle while in_stall_o is low; the verdict for a final byte is registered into the result buffer.
// Parser state updates in the accepting cycle; a two-entry result buffer
// decouples the output, so bytes keep flowing while a verdict waits.
// in_stall_o rises only when both buffer entries hold untaken verdicts.
// Reset loads the default config values and clears the parser.
module adv_uuid128_prefix_filter import aupf_pkg::*; #(
  parameter int unsigned MAX_ADV_LEN  = 31,
  parameter int unsigned PREFIX_BYTES = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          payload_byte_i,
  input  logic                final_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          verdict_o,
  output logic [5:0]          bytes_seen_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    accept;
  logic    push;
  logic    full;
  result_t res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.list_type   <= ListTypeRst;
      cfg_q.prefix_head <= PrefixHeadRst;
      cfg_q.prefix_tail <= PrefixTailRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIST_TYPE:   cfg_q.list_type   <= cfg_data_i[7:0];
        CFG_PREFIX_HEAD: cfg_q.prefix_head <= cfg_data_i;
        CFG_PREFIX_TAIL: cfg_q.prefix_tail <= cfg_data_i[15:0];
        default:         ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  aupf_parse #(
    .MAX_ADV_LEN  (MAX_ADV_LEN),
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .payload_byte_i (payload_byte_i),
    .final_byte_i   (final_byte_i),
    .cfg_i          (cfg_q),
    .push_o         (push),
    .result_o       (res_in)
  );

  aupf_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .result_i    (res_in),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res_out)
  );

  assign verdict_o    = res_out.verdict;
  assign bytes_seen_o = res_out.bytes_seen;

endmodule
